@@ sv/sipd_pkg.sv @@
`timescale 1ns / 1ps
package sipd_pkg;

  localparam int unsigned MaxFrameBytes = 2048;
  localparam logic [15:0] EtherTypeIpv4 = 16'h0800;
  localparam logic [7:0]  ProtoTcp      = 8'd6;
  localparam logic [7:0]  ProtoUdp      = 8'd17;
  localparam logic [15:0] EthHdrLen     = 16'd14;
  localparam logic [4:0]  SipHdrLen     = 5'd16;
  localparam logic [15:0] ServiceAll    = 16'hFFFF;
  localparam logic [7:0]  SipVersion    = 8'h01;
  localparam logic [7:0]  TpFlag        = 8'b0010_0000;

  localparam logic KindHeader  = 1'b0;
  localparam logic KindPayload = 1'b1;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic        record_kind;
    logic [15:0] srv_id;
    logic [15:0] mth_id;
    logic [31:0] message_length;
    logic [15:0] cli_id;
    logic [15:0] ses_id;
    logic [7:0]  message_type;
    logic [7:0]  ret_code;
    logic [7:0]  payload_byte;
    logic        is_segment;
    logic        over_tcp;
    logic        last_of_message;
  } out_item_t;

  // Classified byte handed from the front to the back
  typedef struct packed {
    logic [7:0] data;
    logic       frame_end;
    logic       eth;        // byte belongs to the Ethernet header
    logic       sip;        // byte lies in the SOME/IP section
    logic       first_sip;  // first byte after the transport header
    logic       end_here;   // datagram, frame or size limit ends on this byte
    logic       is_tcp;
  } cls_t;

endpackage

@@ sv/sipd_front.sv @@
`timescale 1ns / 1ps
// Byte classifier: tracks Ethernet, IPv4 and UDP/TCP header positions
module sipd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sipd_pkg::in_item_t in_data_i,
  output logic              cls_valid_o,
  input  logic              cls_ready_i,
  output sipd_pkg::cls_t    cls_o,
  input  logic              sip_drop_i   // back has ended SOME/IP parsing
);

  typedef enum logic [2:0] {PhEth, PhIp, PhTrans, PhSip, PhDrop} phase_e;

  localparam logic [15:0] EthHdrLenW = sipd_pkg::EthHdrLen;

  phase_e      ph_q, ph_d;
  logic [15:0] pos_q, pos_d;
  logic [15:0] tot_q, tot_d;
  logic [5:0]  iphl_q, iphl_d;
  logic [5:0]  tcphl_q, tcphl_d;
  logic        tcp_q, tcp_d;
  logic [15:0] et_q, et_d;
  logic        first_q, first_d;

  logic        acc;
  logic [7:0]  b;
  logic [16:0] dend, p1;
  logic [15:0] o, t;
  logic        over_max, past_end;
  phase_e      ph_eff;

  assign in_ready_o = cls_ready_i;
  assign acc        = in_valid_i && in_ready_o;
  assign b          = in_data_i.frame_byte;
  assign dend       = {1'b0, EthHdrLenW} + {1'b0, tot_q};
  assign p1         = {1'b0, pos_q} + 17'd1;
  assign o          = pos_q - sipd_pkg::EthHdrLen;
  assign t          = o - {10'd0, iphl_q};
  assign over_max   = pos_q >= 16'(sipd_pkg::MaxFrameBytes);
  assign past_end   = {1'b0, pos_q} >= dend;

  // Phase with the drop conditions applied before this byte
  always_comb begin
    ph_eff = ph_q;
    if (ph_q == PhSip && sip_drop_i) ph_eff = PhDrop;
    if (over_max) ph_eff = PhDrop;
    if ((ph_eff == PhTrans || ph_eff == PhSip) && past_end) ph_eff = PhDrop;
  end

  // Next-state logic
  always_comb begin
    ph_d = ph_eff; pos_d = pos_q; tot_d = tot_q; iphl_d = iphl_q;
    tcphl_d = tcphl_q; tcp_d = tcp_q; et_d = et_q; first_d = first_q;
    if (acc) begin
      if (ph_eff == PhSip) first_d = 1'b0;
      case (ph_eff)
        PhEth: begin
          et_d = {et_q[7:0], b};
          if (pos_q == sipd_pkg::EthHdrLen - 16'd1)
            ph_d = ({et_q[7:0], b} == sipd_pkg::EtherTypeIpv4) ? PhIp : PhDrop;
        end
        PhIp: begin
          if (o == 16'd0) begin
            iphl_d = {b[3:0], 2'b00};
            if ({b[3:0], 2'b00} < 6'd20) ph_d = PhDrop;
          end else begin
            if (o == 16'd2) tot_d = {b, 8'h00};
            else if (o == 16'd3) tot_d = {tot_q[15:8], b};
            else if (o == 16'd9) begin
              if (b == sipd_pkg::ProtoTcp) tcp_d = 1'b1;
              else if (b == sipd_pkg::ProtoUdp) tcp_d = 1'b0;
              else ph_d = PhDrop;
            end
            if (ph_d == PhIp && o + 16'd1 == {10'd0, iphl_q}) ph_d = PhTrans;
          end
        end
        PhTrans: begin
          if (!tcp_q) begin
            if (t == 16'd7) begin ph_d = PhSip; first_d = 1'b1; end
          end else if (t == 16'd12) begin
            tcphl_d = {b[7:4], 2'b00};
            if ({b[7:4], 2'b00} < 6'd20) ph_d = PhDrop;
          end else if (t > 16'd12 && t + 16'd1 == {10'd0, tcphl_q}) begin
            ph_d = PhSip; first_d = 1'b1;
          end
        end
        PhSip: ;
        default: ph_d = PhDrop;
      endcase
      if (pos_q != 16'hFFFF) pos_d = pos_q + 16'd1;
      if (in_data_i.frame_end) begin
        ph_d = PhEth; pos_d = '0; tot_d = '0; iphl_d = '0; tcphl_d = '0;
        tcp_d = 1'b0; first_d = 1'b0;
      end
    end
  end

  // Classified byte towards the back
  always_comb begin
    cls_valid_o     = in_valid_i;
    cls_o.data      = b;
    cls_o.frame_end = in_data_i.frame_end;
    cls_o.eth       = (ph_eff == PhEth);
    cls_o.sip       = (ph_eff == PhSip);
    cls_o.first_sip = first_q;
    cls_o.end_here  = in_data_i.frame_end || (p1 >= dend) ||
                      (p1 >= 17'(sipd_pkg::MaxFrameBytes));
    cls_o.is_tcp    = tcp_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PhEth; pos_q <= '0; tot_q <= '0; iphl_q <= '0; tcphl_q <= '0;
      tcp_q <= 1'b0; et_q <= '0; first_q <= 1'b0;
    end else begin
      ph_q <= ph_d; pos_q <= pos_d; tot_q <= tot_d; iphl_q <= iphl_d;
      tcphl_q <= tcphl_d; tcp_q <= tcp_d; et_q <= et_d; first_q <= first_d;
    end
  end

endmodule

@@ sv/sipd_fifo.sv @@
`timescale 1ns / 1ps
// Two-entry queue between the classifier and the record builder
module sipd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_valid_i,
  output logic           wr_ready_o,
  input  sipd_pkg::cls_t wr_data_i,
  output logic           rd_valid_o,
  input  logic           rd_ready_i,
  output sipd_pkg::cls_t rd_data_o
);

  sipd_pkg::cls_t mem_q [2];
  logic           wp_q, rp_q;
  logic [1:0]     cnt_q;
  logic           wr, rd;

  assign wr_ready_o = cnt_q != 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign rd_data_o  = mem_q[rp_q];
  assign wr         = wr_valid_i && wr_ready_o;
  assign rd         = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

@@ sv/sipd_back.sv @@
`timescale 1ns / 1ps
// Record builder: gathers SOME/IP headers, checks them, emits records
module sipd_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cls_valid_i,
  output logic               cls_ready_o,
  input  sipd_pkg::cls_t     cls_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sipd_pkg::out_item_t out_data_o,
  output logic               sip_drop_o
);

  typedef enum logic [1:0] {StHdr, StPay, StDrop} st_e;

  st_e         st_q, st_d;
  logic [63:0] h0_q, h0_d, h1_q, h1_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] rem_q, rem_d;
  logic        tcp_q, tcp_d;
  logic        ov_q, ov_d;
  sipd_pkg::out_item_t od_q, od_d;
  logic        acc, emit;
  logic [63:0] n0, n1;
  logic [31:0] rdec, plen;
  logic        bad;
  st_e         st_eff;
  sipd_pkg::out_item_t rec;

  // Output register may be refilled while it is being taken
  assign cls_ready_o = !ov_q || out_ready_i;
  assign acc         = cls_valid_i && cls_ready_o;
  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;
  // tell the front no more SOME/IP in this frame (only while dropping)
  assign sip_drop_o  = (st_q == StDrop) && !(acc && cls_i.frame_end);

  assign n0   = {h0_q[55:0], h1_q[63:56]};
  assign n1   = {h1_q[55:0], cls_i.data};
  assign plen = n0[31:0] - 32'd8;
  assign rdec = rem_q - 32'd1;
  assign bad  = (n1[15:8] == 8'd0) || (n0[63:48] == sipd_pkg::ServiceAll) ||
                (n1[31:24] != sipd_pkg::SipVersion) ||
                (n1[23:16] != sipd_pkg::SipVersion) || (n0[31:0] < 32'd8);

  always_comb begin
    st_eff = cls_i.first_sip ? StHdr : st_q;
  end

  always_comb begin
    st_d = st_q; h0_d = h0_q; h1_d = h1_q; cnt_d = cnt_q; rem_d = rem_q;
    tcp_d = tcp_q; emit = 1'b0;
    rec = '0;
    if (acc) begin
      if (cls_i.first_sip) begin
        tcp_d = cls_i.is_tcp; cnt_d = '0; st_d = StHdr;
      end
      if (cls_i.eth) begin
        h0_d = n0; h1_d = n1;
      end else if (cls_i.sip) begin
        case (st_eff)
          StHdr: begin
            h0_d = n0; h1_d = n1;
            if (cnt_d + 5'd1 >= sipd_pkg::SipHdrLen) begin
              cnt_d = '0;
              if (bad) st_d = StDrop;
              else begin
                emit = 1'b1;
                rem_d = plen;
                rec.record_kind = sipd_pkg::KindHeader;
                rec.srv_id = n0[63:48]; rec.mth_id = n0[47:32];
                rec.message_length = n0[31:0];
                rec.cli_id = n1[63:48]; rec.ses_id = n1[47:32];
                rec.message_type = n1[15:8]; rec.ret_code = n1[7:0];
                rec.is_segment = !cls_i.is_tcp && |(n1[15:8] & sipd_pkg::TpFlag);
                rec.over_tcp = cls_i.is_tcp;
                rec.last_of_message = (plen == 32'd0) || cls_i.end_here;
                if (plen == 32'd0) st_d = cls_i.is_tcp ? StDrop : StHdr;
                else st_d = StPay;
              end
            end else cnt_d = cnt_d + 5'd1;
          end
          StPay: begin
            emit = 1'b1;
            rem_d = rdec;
            rec.record_kind = sipd_pkg::KindPayload;
            rec.srv_id = h0_q[63:48]; rec.mth_id = h0_q[47:32];
            rec.message_length = h0_q[31:0];
            rec.cli_id = h1_q[63:48]; rec.ses_id = h1_q[47:32];
            rec.message_type = h1_q[15:8]; rec.ret_code = h1_q[7:0];
            rec.payload_byte = cls_i.data;
            rec.is_segment = !tcp_q && |(h1_q[15:8] & sipd_pkg::TpFlag);
            rec.over_tcp = tcp_q;
            rec.last_of_message = (rdec == 32'd0) || cls_i.end_here;
            if (rdec == 32'd0) begin
              cnt_d = '0; st_d = tcp_q ? StDrop : StHdr;
            end
          end
          default: ;
        endcase
      end
      if (cls_i.frame_end) begin
        st_d = StHdr; cnt_d = '0; rem_d = '0; tcp_d = 1'b0;
      end
    end
    ov_d = emit ? 1'b1 : (out_ready_i ? 1'b0 : ov_q);
    od_d = emit ? rec : od_q;
  end

  always_ff @(posedge clk_i) begin
    od_q <= od_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StHdr; h0_q <= '0; h1_q <= '0; cnt_q <= '0; rem_q <= '0;
      tcp_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      st_q <= st_d; h0_q <= h0_d; h1_q <= h1_d; cnt_q <= cnt_d; rem_q <= rem_d;
      tcp_q <= tcp_d; ov_q <= ov_d;
    end
  end

endmodule

@@ sv/someip_frame_deframer.sv @@
`timescale 1ns / 1ps
// Channel  | Signals                              | Payload
// ---------+--------------------------------------+----------------------
// frame in | in_valid_i / in_ready_o / in_data_i  | sipd_pkg::in_item_t
// records  | out_valid_o / out_ready_i / out_data_o | sipd_pkg::out_item_t
//
// One byte per cycle while the output is not stalled; a record passes through the queue and the back's output register.
// The front classifies bytes by header position, the back builds records.
// Reset clears all parse state; the frame_end byte returns the parse to start.
// A stalled output backs up the two-entry queue, then the input.
module someip_frame_deframer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sipd_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sipd_pkg::out_item_t out_data_o
);

  logic           f_valid, f_ready, b_valid, b_ready, sip_drop;
  sipd_pkg::cls_t f_data, b_data;

  // the front heeds the drop flag only in its SOME/IP phase;
  // the front stalls on full queue so the back's view can lag one request
  sipd_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .cls_valid_o(f_valid), .cls_ready_i(f_ready), .cls_o(f_data),
    .sip_drop_i(sip_drop)
  );

  sipd_fifo u_fifo (
    .clk_i, .rst_ni, .wr_valid_i(f_valid), .wr_ready_o(f_ready),
    .wr_data_i(f_data), .rd_valid_o(b_valid), .rd_ready_i(b_ready),
    .rd_data_o(b_data)
  );

  sipd_back u_back (
    .clk_i, .rst_ni, .cls_valid_i(b_valid), .cls_ready_o(b_ready),
    .cls_i(b_data), .out_valid_o, .out_ready_i, .out_data_o,
    .sip_drop_o(sip_drop)
  );

endmodule
